// ----- rtl/mlp331_pkg.sv -----
package mlp331_pkg;

    localparam int NUM_INPUTS  = 3;
    localparam int NUM_HIDDEN  = 3;
    localparam int WEIGHT_BITS = 16;

    localparam int NUM_W1      = NUM_INPUTS * NUM_HIDDEN;
    localparam int NUM_WEIGHTS = NUM_W1 + NUM_HIDDEN;
    localparam int W_IDX_W     = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam int MAX_TERMS   = (NUM_INPUTS > NUM_HIDDEN) ? NUM_INPUTS : NUM_HIDDEN;
    localparam int TERM_W      = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int NEUR_W      = $clog2(NUM_HIDDEN + 1);
    localparam int H_IDX_W     = (NUM_HIDDEN > 1) ? $clog2(NUM_HIDDEN) : 1;

    // Shared multiplier: A carries x, h or the sigmoid slope, B a weight or the fraction
    localparam int A_W   = 17;
    localparam int B_W   = (WEIGHT_BITS > 12) ? WEIGHT_BITS : 12;
    localparam int P_W   = A_W + B_W;
    localparam int ACC_W = P_W + TERM_W + 1;

    localparam int LEVEL_W = 16;
    localparam int X_W     = 13;
    localparam int THR_W   = 13;
    localparam int MODE_W  = 2;

    localparam logic [MODE_W-1:0] MODE_SIGMOID = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LINEAR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STEP    = 2'd2;

    localparam int NUM_REGS   = 2;
    localparam int PADDR_W    = $clog2(NUM_REGS * 4);
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [REG_IDX_W-1:0] REG_MODE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_THR  = 1'd1;

    localparam logic [THR_W-1:0] THR_RESET = 13'd2048;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [THR_W-1:0]  thr;
    } t_cfg;

    typedef struct packed {
        logic               load_x;
        logic               wr_weight;
        logic               mac;
        logic               use_h;
        logic [TERM_W-1:0]  term;
        logic [W_IDX_W-1:0] w_idx;
        logic               round;
        logic               act;
        logic               h_wr;
        logic [H_IDX_W-1:0] h_idx;
        logic               out_load;
    } t_cmd;

    typedef struct packed {
        logic slot_free;
    } t_sts;

    // sigmoid(k/2), Q0.12
    function automatic logic [11:0] sig_entry(input logic [4:0] k);
        logic [11:0] v;
        case (k)
            5'd0:    v = 12'd2048;
            5'd1:    v = 12'd2550;
            5'd2:    v = 12'd2994;
            5'd3:    v = 12'd3349;
            5'd4:    v = 12'd3608;
            5'd5:    v = 12'd3785;
            5'd6:    v = 12'd3902;
            5'd7:    v = 12'd3976;
            5'd8:    v = 12'd4022;
            5'd9:    v = 12'd4051;
            5'd10:   v = 12'd4069;
            5'd11:   v = 12'd4079;
            5'd12:   v = 12'd4086;
            5'd13:   v = 12'd4090;
            5'd14:   v = 12'd4092;
            5'd15:   v = 12'd4094;
            default: v = 12'd4095;
        endcase
        return v;
    endfunction

    // floor((b*4096 + 127) / 255) = b*16 + floor((b*16 + 127) / 255)
    function automatic logic [X_W-1:0] scale_byte(input logic [7:0] b);
        logic [12:0] v;
        logic [12:0] t;
        v = {1'b0, b, 4'b0000} + 13'd127;
        t = v + 13'd1 + 13'(v[12:8]);
        return 13'({b, 4'b0000}) + 13'(t[12:8]);
    endfunction

endpackage

// ----- rtl/mlp331_if.sv -----
interface mlp331_in_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [3:0]  weight_index;
    logic signed [15:0] weight_value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;

    modport source (
        output valid, action, weight_index, weight_value, red, green, blue,
        input  ready
    );
    modport sink (
        input  valid, action, weight_index, weight_value, red, green, blue,
        output ready
    );
endinterface

interface mlp331_out_if;
    logic        valid;
    logic        ready;
    logic signed [15:0] output_level;
    logic        positive;

    modport source (
        output valid, output_level, positive,
        input  ready
    );
    modport sink (
        input  valid, output_level, positive,
        output ready
    );
endinterface

// ----- rtl/mlp_3_3_1_classifier_core.sv -----
// Three-input, three-hidden, one-output perceptron colour classifier, Q4.12 fixed point.
// An input transfer with action 0 stores one signed weight (index input*3+hidden for the
// first layer, 9..11 for the output layer; higher indexes are dropped) and
// gives no result. A transfer with action 1 scales red, green and blue to x/255, runs both
// layers with the activation chosen in register 0 and returns the output level and a flag
// that is set when the level is above the threshold in register 1 (APB offsets 0x0 and 0x4).
// A classify transfer occupies the block until its result is loaded into the output register,
// and no next input is taken before then: one shared multiplier forms every product and each
// sigmoid interpolation in turn, and each neuron spends a rounding step and an activation step
// after its products. A finished result waits in an output register; the block stalls on the
// last step only while that register is still full.
module mlp_3_3_1_classifier_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mlp331_in_if.sink                      i_in,
    mlp331_out_if.source                   o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mlp331_pkg::PADDR_W-1:0] paddr,
    input  logic [mlp331_pkg::PDATA_W-1:0] pwdata,
    output logic [mlp331_pkg::PDATA_W-1:0] prdata,
    output logic                           pready
);

    mlp331_pkg::t_cfg cfg;
    mlp331_pkg::t_cmd cmd;
    mlp331_pkg::t_sts sts;
    logic             in_ready;

    mlp331_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mlp331_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .i_sts       (sts),
        .o_in_ready  (in_ready),
        .o_cmd       (cmd)
    );

    mlp331_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg          (cfg),
        .i_weight_index (i_in.weight_index),
        .i_weight_value (i_in.weight_value),
        .i_red          (i_in.red),
        .i_green        (i_in.green),
        .i_blue         (i_in.blue),
        .i_out_ready    (o_out.ready),
        .o_sts          (sts),
        .o_out_valid    (o_out.valid),
        .o_output_level (o_out.output_level),
        .o_positive     (o_out.positive)
    );

    assign i_in.ready = in_ready;

endmodule

// ----- rtl/mlp331_regs.sv -----
module mlp331_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mlp331_pkg::PADDR_W-1:0]      paddr,
    input  logic [mlp331_pkg::PDATA_W-1:0]      pwdata,
    output logic [mlp331_pkg::PDATA_W-1:0]      prdata,
    output logic                                pready,
    output mlp331_pkg::t_cfg                    o_cfg
);

    logic [mlp331_pkg::MODE_W-1:0]    r_mode;
    logic [mlp331_pkg::THR_W-1:0]     r_thr;
    logic [mlp331_pkg::REG_IDX_W-1:0] reg_idx;
    logic                             wr_en;

    assign reg_idx = paddr[mlp331_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= mlp331_pkg::MODE_SIGMOID;
            r_thr  <= mlp331_pkg::THR_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                mlp331_pkg::REG_MODE: r_mode <= pwdata[mlp331_pkg::MODE_W-1:0];
                mlp331_pkg::REG_THR:  r_thr  <= pwdata[mlp331_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            mlp331_pkg::REG_MODE: prdata = mlp331_pkg::PDATA_W'(r_mode);
            mlp331_pkg::REG_THR:  prdata = mlp331_pkg::PDATA_W'(r_thr);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.mode = r_mode;
    assign o_cfg.thr  = r_thr;

endmodule

// ----- rtl/mlp331_ctrl.sv -----
module mlp331_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_action,
    input  mlp331_pkg::t_sts  i_sts,
    output logic              o_in_ready,
    output mlp331_pkg::t_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MAC   = 2'd1;
    localparam logic [1:0] S_ROUND = 2'd2;
    localparam logic [1:0] S_ACT   = 2'd3;

    localparam logic [mlp331_pkg::NEUR_W-1:0] OUT_NEURON =
        mlp331_pkg::NEUR_W'(mlp331_pkg::NUM_HIDDEN);
    localparam logic [mlp331_pkg::TERM_W-1:0] LAST_IN_TERM =
        mlp331_pkg::TERM_W'(mlp331_pkg::NUM_INPUTS - 1);
    localparam logic [mlp331_pkg::TERM_W-1:0] LAST_H_TERM =
        mlp331_pkg::TERM_W'(mlp331_pkg::NUM_HIDDEN - 1);

    logic [1:0]                      r_state,  n_state;
    logic [mlp331_pkg::NEUR_W-1:0]   r_neuron, n_neuron;
    logic [mlp331_pkg::TERM_W-1:0]   r_term,   n_term;
    logic                            in_xfer;
    logic                            at_out;
    logic                            last_term;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign at_out     = (r_neuron == OUT_NEURON);
    assign last_term  = at_out ? (r_term == LAST_H_TERM) : (r_term == LAST_IN_TERM);

    always_comb begin
        n_state  = r_state;
        n_neuron = r_neuron;
        n_term   = r_term;

        o_cmd           = '0;
        o_cmd.use_h     = at_out;
        o_cmd.term      = r_term;
        o_cmd.h_idx     = mlp331_pkg::H_IDX_W'(r_neuron);
        // hidden neuron j, input i: weight i*NH + j; output neuron: after the first layer
        o_cmd.w_idx     = at_out
            ? mlp331_pkg::W_IDX_W'(mlp331_pkg::NUM_W1 + int'(r_term))
            : mlp331_pkg::W_IDX_W'(int'(r_term) * mlp331_pkg::NUM_HIDDEN + int'(r_neuron));

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_action) begin
                        o_cmd.load_x = 1'b1;
                        n_state      = S_MAC;
                        n_neuron     = '0;
                        n_term       = '0;
                    end else begin
                        o_cmd.wr_weight = 1'b1;
                    end
                end
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (last_term) begin
                    n_term  = '0;
                    n_state = S_ROUND;
                end else begin
                    n_term = r_term + 1'b1;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_ACT;
            end
            S_ACT: begin
                o_cmd.act = 1'b1;
                if (!at_out) begin
                    o_cmd.h_wr = 1'b1;
                    n_neuron   = r_neuron + 1'b1;
                    n_state    = S_MAC;
                end else if (i_sts.slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_neuron <= '0;
            r_term   <= '0;
        end else begin
            r_state  <= n_state;
            r_neuron <= n_neuron;
            r_term   <= n_term;
        end
    end

endmodule

// ----- rtl/mlp331_dpath.sv -----
module mlp331_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mlp331_pkg::t_cmd   i_cmd,
    input  mlp331_pkg::t_cfg   i_cfg,
    input  logic [3:0]         i_weight_index,
    input  logic signed [15:0] i_weight_value,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    input  logic               i_out_ready,
    output mlp331_pkg::t_sts   o_sts,
    output logic               o_out_valid,
    output logic signed [15:0] o_output_level,
    output logic               o_positive
);

    localparam int ACC_W = mlp331_pkg::ACC_W;
    localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_LO   = -ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(2048);

    logic signed [mlp331_pkg::WEIGHT_BITS-1:0] r_w [mlp331_pkg::NUM_WEIGHTS];
    logic [mlp331_pkg::X_W-1:0]                r_x [mlp331_pkg::NUM_INPUTS];
    logic signed [15:0]                        r_h [mlp331_pkg::NUM_HIDDEN];
    logic signed [ACC_W-1:0]                   r_acc;
    logic signed [15:0]                        r_lvl;
    logic                                      r_out_valid;
    logic signed [15:0]                        r_out_level;
    logic                                      r_out_pos;

    logic [7:0]                           rgb [3];
    logic signed [mlp331_pkg::A_W-1:0]    mul_a;
    logic signed [mlp331_pkg::B_W-1:0]    mul_b;
    logic signed [mlp331_pkg::P_W-1:0]    prod;
    logic signed [ACC_W-1:0]              rnd_sum;
    logic signed [ACC_W-1:0]              rnd_shr;
    logic signed [15:0]                   rnd_val;

    logic                                 neg;
    logic [16:0]                          mag;
    logic                                 beyond;
    logic [3:0]                           seg;
    logic [11:0]                          base;
    logic [8:0]                           slope;
    logic [20:0]                          interp_raw;
    logic [12:0]                          interp;
    logic [12:0]                          sig_val;
    logic signed [15:0]                   act_val;
    logic                                 act_pos;

    assign rgb[0] = i_red;
    assign rgb[1] = i_green;
    assign rgb[2] = i_blue;

    // Sigmoid: |v| in half-unit segments, interpolation through the shared multiplier
    always_comb begin
        neg    = r_lvl[15];
        mag    = neg ? (17'd0 - {r_lvl[15], r_lvl}) : {1'b0, r_lvl};
        beyond = (mag[16:15] != 2'b00);
        seg    = mag[14:11];
        base   = beyond ? 12'd4095 : mlp331_pkg::sig_entry({1'b0, seg});
        slope  = beyond ? 9'd0
                        : 9'(mlp331_pkg::sig_entry(5'(seg) + 5'd1)
                             - mlp331_pkg::sig_entry({1'b0, seg}));
    end

    always_comb begin
        if (i_cmd.act) begin
            mul_a = mlp331_pkg::A_W'($signed({1'b0, slope}));
            mul_b = mlp331_pkg::B_W'($signed({1'b0, mag[10:0]}));
        end else begin
            mul_a = i_cmd.use_h ? mlp331_pkg::A_W'(r_h[mlp331_pkg::H_IDX_W'(i_cmd.term)])
                                : mlp331_pkg::A_W'($signed({1'b0, r_x[i_cmd.term]}));
            mul_b = mlp331_pkg::B_W'(r_w[i_cmd.w_idx]);
        end
        prod = mul_a * mul_b;
    end

    always_comb begin
        interp_raw = prod[20:0] + 21'd1024;
        interp     = 13'(base) + 13'(interp_raw[20:11]);
        sig_val    = neg ? (13'd4096 - interp) : interp;
        case (i_cfg.mode)
            mlp331_pkg::MODE_SIGMOID: act_val = 16'($signed({1'b0, sig_val}));
            mlp331_pkg::MODE_LINEAR:  act_val = r_lvl;
            mlp331_pkg::MODE_STEP:    act_val = (r_lvl > 16'sd2048) ? 16'sd4096 : 16'sd0;
            default:                  act_val = -16'sd8192;
        endcase
        act_pos = $signed({act_val[15], act_val}) > $signed({4'b0000, i_cfg.thr});
    end

    // Q.24 sum to Q.12, half up, then saturate to 16 bits
    always_comb begin
        rnd_sum = r_acc + RND_HALF;
        rnd_shr = rnd_sum >>> 12;
        if (rnd_shr > SAT_HI) begin
            rnd_val = 16'sd32767;
        end else if (rnd_shr < SAT_LO) begin
            rnd_val = -16'sd32768;
        end else begin
            rnd_val = rnd_shr[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < mlp331_pkg::NUM_WEIGHTS; k++) begin
                r_w[k] <= '0;
            end
        end else if (i_cmd.wr_weight && (int'(i_weight_index) < mlp331_pkg::NUM_WEIGHTS)) begin
            r_w[mlp331_pkg::W_IDX_W'(i_weight_index)] <=
                mlp331_pkg::WEIGHT_BITS'(i_weight_value);
        end
    end

    for (genvar gi = 0; gi < mlp331_pkg::NUM_INPUTS; gi++) begin : g_x
        if (gi < 3) begin : g_byte
            always_ff @(posedge i_clk) begin
                if (i_cmd.load_x) begin
                    r_x[gi] <= mlp331_pkg::scale_byte(rgb[gi]);
                end
            end
        end else begin : g_zero
            always_ff @(posedge i_clk) begin
                if (i_cmd.load_x) begin
                    r_x[gi] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x || i_cmd.round) begin
            r_acc <= '0;
        end else if (i_cmd.mac) begin
            r_acc <= r_acc + ACC_W'(prod);
        end
        if (i_cmd.round) begin
            r_lvl <= rnd_val;
        end
        if (i_cmd.h_wr) begin
            r_h[i_cmd.h_idx] <= act_val;
        end
        if (i_cmd.out_load) begin
            r_out_level <= act_val;
            r_out_pos   <= act_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_output_level  = r_out_level;
    assign o_positive      = r_out_pos;

endmodule

// ----- rtl/mlp331_checker.sv -----
module mlp331_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_in_action,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_out_level,
    input logic        i_out_positive
);

    // result held until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_level) && $stable(i_out_positive))
        else $error("stalled result changed");

    // a weight write never produces a result
    a_wr_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_action && !i_out_valid |=> !i_out_valid)
        else $error("result after weight write");

    // a classify transfer keeps the input side closed while the layers run
    a_busy_after_classify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_action |=> !i_in_ready ##1 !i_in_ready)
        else $error("input taken while classifying");

endmodule

bind mlp_3_3_1_classifier_core mlp331_checker u_mlp331_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_action    (i_in.action),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_level    (o_out.output_level),
    .i_out_positive (o_out.positive)
);
